### design/aptu_pkg.sv
// Shared types and constants for the AABB pair contact tracker.
`default_nettype none

package aptu_pkg;

  localparam int LAYER_COUNT = 8;
  localparam int MATRIX_W    = 64;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } event_t;

  typedef struct packed {
    logic [2:0]         left_layer;
    logic [2:0]         right_layer;
    logic [5:0]         left_id;
    logic [5:0]         right_id;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic [14:0]        left_w;
    logic [14:0]        left_h;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [14:0]        right_w;
    logic [14:0]        right_h;
  } pair_t;

  typedef struct packed {
    event_t     event_res;
    logic       overlap;
    logic [5:0] first_id;
    logic [5:0] second_id;
  } result_t;

endpackage

`default_nettype wire

### design/aptu_pair_if.sv
// Valid/ready channel carrying one candidate box pair word.
`default_nettype none

interface aptu_pair_if;
  logic           valid;
  logic           ready;
  aptu_pkg::pair_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/aptu_result_if.sv
// Valid/ready channel carrying one contact result word.
`default_nettype none

interface aptu_result_if;
  logic             valid;
  logic             ready;
  aptu_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/aabb_pair_contact_tracker_unit.sv
// AABB pair contact tracker: layer filter, overlap test and contact table update.
//
// Usage:
//   pair   - sink channel, one candidate box pair word per handshake.
//   result - source channel, exactly one result word per accepted pair word,
//            in order: event (none/enter/stay/exit), overlap flag, id echoes.
//   cfg_we / cfg_wdata - write of the 64-bit layer matrix; write only while
//            no pair word is in flight.
// Path: an accepted pair word is registered in the input stage, then in the
// result register, from which its result word is offered. Throughput: one word
// per cycle while result.ready is high and no sweep is running; the contact
// table is read as the word is accepted and written as it leaves the input
// stage, with a bypass between back-to-back words on the same id pair.
// Reset: the layer matrix is cleared and the contact table is swept one row
// per cycle over MIN(MAX_COLLIDERS, 64) rows (64 at the default); pair.ready
// stays low during the sweep.
// Stall: while result.ready is low the result register holds its word, the
// input stage keeps one more, and pair.ready drops once both are full.
`default_nettype none

module aabb_pair_contact_tracker_unit #(
  parameter int MAX_COLLIDERS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  aptu_pair_if.sink                            pair,
  aptu_result_if.source                        result,
  input  wire logic                            cfg_we,
  input  wire logic [aptu_pkg::MATRIX_W-1:0]   cfg_wdata
);

  localparam int ID_SPAN = (MAX_COLLIDERS < 64) ? MAX_COLLIDERS : 64;
  localparam int IDX_W   = $clog2(ID_SPAN);

  function automatic logic axis_hit(input logic signed [15:0] lp, input logic [14:0] ls,
                                    input logic signed [15:0] rp, input logic [14:0] rs);
    logic [18:0] lc;
    logic [18:0] rc;
    logic [18:0] d;
    logic [18:0] mag;
    logic [15:0] span;
    lc   = {{2{lp[15]}}, lp, 1'b0} + {4'b0000, ls};
    rc   = {{2{rp[15]}}, rp, 1'b0} + {4'b0000, rs};
    d    = lc - rc;
    mag  = d[18] ? (19'd0 - d) : d;
    span = {1'b0, ls} + {1'b0, rs};
    return mag < {3'b000, span};
  endfunction

  logic [aptu_pkg::MATRIX_W-1:0] layer_matrix;
  logic [ID_SPAN-1:0] contact_mem [ID_SPAN];
  logic               clearing;
  logic [IDX_W-1:0]   clr_row;

  logic               s1_valid;
  aptu_pkg::pair_t    s1;
  logic               was;

  logic               res_valid;
  aptu_pkg::result_t  res;
  aptu_pkg::result_t  res_next;

  logic               s1_adv;
  logic               accept;
  logic               layer_ok;
  logic               id_ok;
  logic               checked;
  logic               hit;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_row;
  logic [IDX_W-1:0]   wr_col;
  logic [IDX_W-1:0]   rd_row;
  logic [IDX_W-1:0]   rd_col;

  assign s1_adv       = !res_valid || result.ready;
  assign pair.ready   = !clearing && (!s1_valid || s1_adv);
  assign accept       = pair.valid && pair.ready;
  assign result.valid = res_valid;
  assign result.data  = res;

  assign wr_row = s1.left_id[IDX_W-1:0];
  assign wr_col = s1.right_id[IDX_W-1:0];
  assign rd_row = pair.data.left_id[IDX_W-1:0];
  assign rd_col = pair.data.right_id[IDX_W-1:0];

  always_comb begin
    layer_ok = (4'({1'b0, s1.left_layer}) < 4'(aptu_pkg::LAYER_COUNT))
            && (4'({1'b0, s1.right_layer}) < 4'(aptu_pkg::LAYER_COUNT))
            && layer_matrix[{s1.left_layer, s1.right_layer}];
    id_ok    = (s1.left_id != s1.right_id)
            && (32'(s1.left_id) < 32'(MAX_COLLIDERS))
            && (32'(s1.right_id) < 32'(MAX_COLLIDERS));
    checked  = layer_ok && id_ok;
    hit      = axis_hit(s1.left_x, s1.left_w, s1.right_x, s1.right_w)
            && axis_hit(s1.left_y, s1.left_h, s1.right_y, s1.right_h);
    wr_en    = s1_valid && s1_adv && checked && (hit != was);
  end

  always_comb begin
    res_next.first_id  = s1.left_id;
    res_next.second_id = s1.right_id;
    res_next.overlap   = checked && hit;
    res_next.event_res = aptu_pkg::EV_NONE;
    if (checked) begin
      if (hit) begin
        res_next.event_res = was ? aptu_pkg::EV_STAY : aptu_pkg::EV_ENTER;
      end else if (was) begin
        res_next.event_res = aptu_pkg::EV_EXIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_matrix <= '0;
    end else if (cfg_we) begin
      layer_matrix <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == IDX_W'(ID_SPAN - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      contact_mem[clr_row] <= '0;
    end else if (wr_en) begin
      contact_mem[wr_row][wr_col] <= hit;
    end
  end

  // bypass the bit being written this cycle to a word on the same id pair
  always_ff @(posedge clk) begin
    if (accept) begin
      if (wr_en && (wr_row == rd_row) && (wr_col == rd_col)) begin
        was <= hit;
      end else begin
        was <= contact_mem[rd_row][rd_col];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= pair.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

### design/aptu_checker.sv
// Port-level checker for the AABB pair contact tracker, bound to the top level.
`default_nettype none

module aptu_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              pair_ready,
  input wire logic              res_valid,
  input wire logic              res_ready,
  input wire aptu_pkg::result_t res_data
);

  a_no_accept_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !pair_ready)
    else $error("pair ready during table sweep");

  a_overlap_event: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.overlap) |->
      (res_data.event_res == aptu_pkg::EV_ENTER || res_data.event_res == aptu_pkg::EV_STAY))
    else $error("overlap without enter or stay");

  a_no_overlap_event: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.overlap) |->
      (res_data.event_res == aptu_pkg::EV_NONE || res_data.event_res == aptu_pkg::EV_EXIT))
    else $error("enter or stay without overlap");

  a_same_id_quiet: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.first_id == res_data.second_id) |->
      (res_data.event_res == aptu_pkg::EV_NONE && !res_data.overlap))
    else $error("event on equal ids");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
    else $error("result word dropped or changed under stall");

endmodule

bind aabb_pair_contact_tracker_unit aptu_checker u_aptu_checker (
  .clk       (clk),
  .rst       (rst),
  .pair_ready(pair.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_data  (result.data)
);

`default_nettype wire
